// ----- src/pidsp_pkg.sv -----
// Shared types and constants for the PID speed loop with PWM output.
package pidsp_pkg;

  // Operand and product widths of the shared multiplier, and the accumulator, register and register index widths.
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 17;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned AccW   = ProdW;
  localparam int unsigned RegW   = 16;
  localparam int unsigned RegIdxW = 3;

  // Register indexes of the configuration port.
  typedef enum logic [RegIdxW-1:0] {
    REG_TARGET_SPEED = 3'd0,
    REG_SPEED_SCALE  = 3'd1,
    REG_GAIN_P       = 3'd2,
    REG_GAIN_I       = 3'd3,
    REG_GAIN_D       = 3'd4,
    REG_BACK_COEFF   = 3'd5,
    REG_OUT_SCALE    = 3'd6
  } reg_idx_e;

  // Sequencer states; apart from S_IDLE, one multiply or update step each.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SPEED,
    S_ERR,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_MUL_B,
    S_ACC,
    S_SCALE,
    S_OUT
  } seq_state_e;

  // Configuration register set.
  typedef struct packed {
    logic [RegW-1:0] target_speed;
    logic [RegW-1:0] speed_scale;
    logic [RegW-1:0] gain_p;
    logic [RegW-1:0] gain_i;
    logic [RegW-1:0] gain_d;
    logic [RegW-1:0] back_coeff;
    logic [RegW-1:0] out_scale;
  } cfg_t;

endpackage

// ----- src/pid_speed_pwm_controller.sv -----
// Top level of the PID speed loop: sequencer, state and result register.
//
// Usage:
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one
// register per cycle, while no sample is in flight. The input channel
// carries one ADC sample per word (in_valid_i, in_stall_o); the output
// channel returns one word per sample (out_valid_o, out_stall_i) holding
// the PWM compare value, the measured speed and the saturation flag.
// Every sample goes through one shared multiplier in six passes (speed,
// P, I, D, back term, output scale) under a small sequencer, and a new
// sample is taken only once the word of the last one is in the output
// register. in_stall_o is high while a sample is being worked on.
// The result sits in an output register; while the receiver stalls, the
// next sample may still be taken and worked on, and the sequencer waits in
// its last step until the register is free.
// Reset clears the configuration registers, the sequencer state, the
// integral sum, the previous error and the output valid flag.
module pid_speed_pwm_controller #(
  parameter int unsigned ADC_WIDTH  = 12,
  parameter int unsigned DUTY_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pidsp_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [pidsp_pkg::RegW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ADC_WIDTH-1:0]          adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [DUTY_WIDTH-1:0]         pwm_duty_o,
  output logic signed [15:0]            measured_speed_o,
  output logic                          clamped_o
);

  localparam int unsigned AW = pidsp_pkg::MulAW;
  localparam int unsigned BW = pidsp_pkg::MulBW;
  localparam int unsigned PW = pidsp_pkg::ProdW;
  localparam int unsigned CW = pidsp_pkg::AccW;

  pidsp_pkg::cfg_t       cfg;
  pidsp_pkg::seq_state_e state_q, state_d;

  logic [ADC_WIDTH-1:0]  adc_q;
  logic [14:0]           speed_q, speed_d;
  logic [16:0]           err_q, err_d;
  logic [17:0]           diff_q, diff_d;
  logic [31:0]           integ_q, integ_d;
  logic [16:0]           prev_q;
  logic [CW-1:0]         acc_q, acc_d;
  logic                  clamp_q, clamp_d;
  logic [32:0]           sum_w;
  logic [15:0]           speed_raw;

  logic signed [AW-1:0]  op_a;
  logic signed [BW-1:0]  op_b;
  logic signed [PW-1:0]  prod;

  logic                  out_valid_q;
  logic [DUTY_WIDTH-1:0] duty_q, duty_d;
  logic [15:0]           mspeed_q;
  logic                  oclamp_q, oclamp_d;
  logic                  load_out;
  logic [31:0]           scaled;

  pidsp_cfg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pidsp_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // Speed, error, difference and saturating sum from the speed product.
  always_comb begin
    speed_raw = prod[31:16];
    speed_d   = speed_raw[15] ? 15'h7fff : speed_raw[14:0];
    err_d     = {cfg.target_speed[15], cfg.target_speed} - {2'b00, speed_d};
    diff_d    = {err_d[16], err_d} - {prev_q[16], prev_q};
    sum_w     = {integ_q[31], integ_q} + {{16{err_d[16]}}, err_d};
    integ_d   = sum_w[31:0];
    if (sum_w[32] != sum_w[31]) begin
      integ_d = sum_w[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      pidsp_pkg::S_SPEED: begin
        op_a = {{(AW-ADC_WIDTH){1'b0}}, adc_q};
        op_b = {1'b0, cfg.speed_scale};
      end
      pidsp_pkg::S_MUL_P: begin
        op_a = {{(AW-17){err_q[16]}}, err_q};
        op_b = {cfg.gain_p[15], cfg.gain_p};
      end
      pidsp_pkg::S_MUL_I: begin
        op_a = {integ_q[31], integ_q};
        op_b = {cfg.gain_i[15], cfg.gain_i};
      end
      pidsp_pkg::S_MUL_D: begin
        op_a = {{(AW-18){diff_q[17]}}, diff_q};
        op_b = {cfg.gain_d[15], cfg.gain_d};
      end
      pidsp_pkg::S_MUL_B: begin
        op_a = {{(AW-15){1'b0}}, speed_q};
        op_b = {cfg.back_coeff[15], cfg.back_coeff};
      end
      pidsp_pkg::S_SCALE: begin
        op_a = {1'b0, acc_q[31:0]};
        op_b = {1'b0, cfg.out_scale};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Duty from the corrected output and its scaled product.
  always_comb begin
    scaled   = prod[47:16];
    duty_d   = scaled[DUTY_WIDTH-1:0];
    oclamp_d = clamp_q;
    if (cfg.out_scale == '0) begin
      duty_d = '0;
    end else if (acc_q[CW-1]) begin
      duty_d   = '0;
      oclamp_d = 1'b1;
    end else if ((|acc_q[CW-2:32]) || (|(scaled >> DUTY_WIDTH))) begin
      duty_d   = '1;
      oclamp_d = 1'b1;
    end
  end

  // Sequencer: next state, accumulator and step updates.
  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    clamp_d    = clamp_q;
    load_out   = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      pidsp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = pidsp_pkg::S_SPEED;
        end
      end
      pidsp_pkg::S_SPEED: state_d = pidsp_pkg::S_ERR;
      pidsp_pkg::S_ERR: begin
        clamp_d = (sum_w[32] != sum_w[31]);
        state_d = pidsp_pkg::S_MUL_P;
      end
      pidsp_pkg::S_MUL_P: begin
        acc_d   = '0;
        state_d = pidsp_pkg::S_MUL_I;
      end
      pidsp_pkg::S_MUL_I: begin
        acc_d   = acc_q + prod;
        state_d = pidsp_pkg::S_MUL_D;
      end
      pidsp_pkg::S_MUL_D: begin
        acc_d   = acc_q + prod;
        state_d = pidsp_pkg::S_MUL_B;
      end
      pidsp_pkg::S_MUL_B: begin
        acc_d   = acc_q + prod;
        state_d = pidsp_pkg::S_ACC;
      end
      pidsp_pkg::S_ACC: begin
        acc_d   = acc_q - prod;
        state_d = pidsp_pkg::S_SCALE;
      end
      pidsp_pkg::S_SCALE: state_d = pidsp_pkg::S_OUT;
      pidsp_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = pidsp_pkg::S_IDLE;
        end
      end
      default: state_d = pidsp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidsp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Loop state: integral sum and previous error, updated once per sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (state_q == pidsp_pkg::S_ERR) begin
      integ_q <= integ_d;
      prev_q  <= err_d;
    end
  end

  // Working registers of the current sample.
  always_ff @(posedge clk_i) begin
    if (state_q == pidsp_pkg::S_IDLE && in_valid_i) begin
      adc_q <= adc_sample_i;
    end
    if (state_q == pidsp_pkg::S_ERR) begin
      speed_q <= speed_d;
      err_q   <= err_d;
      diff_q  <= diff_d;
    end
    acc_q   <= acc_d;
    clamp_q <= clamp_d;
  end

  // Output register; it is freed when the receiver takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      duty_q   <= duty_d;
      mspeed_q <= {1'b0, speed_q};
      oclamp_q <= oclamp_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pwm_duty_o       = duty_q;
  assign measured_speed_o = mspeed_q;
  assign clamped_o        = oclamp_q;

endmodule

// ----- src/pidsp_cfg_regs.sv -----
// Configuration register file of the PID speed loop.
module pidsp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pidsp_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [pidsp_pkg::RegW-1:0]     cfg_wdata_i,
  output pidsp_pkg::cfg_t                cfg_o
);

  pidsp_pkg::cfg_t cfg_q, cfg_d;

  // Decode the index; an unknown index leaves the set unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pidsp_pkg::reg_idx_e'(cfg_idx_i))
        pidsp_pkg::REG_TARGET_SPEED: cfg_d.target_speed = cfg_wdata_i;
        pidsp_pkg::REG_SPEED_SCALE:  cfg_d.speed_scale  = cfg_wdata_i;
        pidsp_pkg::REG_GAIN_P:       cfg_d.gain_p       = cfg_wdata_i;
        pidsp_pkg::REG_GAIN_I:       cfg_d.gain_i       = cfg_wdata_i;
        pidsp_pkg::REG_GAIN_D:       cfg_d.gain_d       = cfg_wdata_i;
        pidsp_pkg::REG_BACK_COEFF:   cfg_d.back_coeff   = cfg_wdata_i;
        pidsp_pkg::REG_OUT_SCALE:    cfg_d.out_scale    = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/pidsp_mul.sv -----
// Shared signed multiplier with a registered product.
module pidsp_mul (
  input  logic                              clk_i,
  input  logic signed [pidsp_pkg::MulAW-1:0] op_a_i,
  input  logic signed [pidsp_pkg::MulBW-1:0] op_b_i,
  output logic signed [pidsp_pkg::ProdW-1:0] prod_o
);

  logic signed [pidsp_pkg::ProdW-1:0] prod_d, prod_q;

  // Full-width signed product; both operands arrive already extended.
  always_comb begin
    prod_d = pidsp_pkg::ProdW'(op_a_i) * pidsp_pkg::ProdW'(op_b_i);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule
